FILE: src/prml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prml_pkg
// Shared types, widths and commands of the policy rule lookup unit.
// ----------------------------------------------------------------------------
package prml_pkg;

    localparam int MAX_RULES = 64;
    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);
    localparam int ORD_W     = 32 + IDX_W;
    localparam int IN_W      = 336;
    localparam int OUT_W     = 40;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic FAM_IPV4 = 1'b0;

    typedef struct packed {
        logic        family;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [7:0]  tos;
        logic [31:0] priority_req;
        logic [31:0] route_table;
        logic        names_interface;
    } rule_t;

    typedef struct packed {
        logic             hit;
        logic [ORD_W-1:0] ord;
    } match_t;

    // IPv4 keeps only the low 32 bits of the low word
    function automatic rule_t mask_rule(input rule_t r);
        rule_t m;
        m = r;
        if (r.family == FAM_IPV4)
        begin
            m.dst_hi = '0;
            m.src_hi = '0;
            m.dst_lo = {32'd0, r.dst_lo[31:0]};
            m.src_lo = {32'd0, r.src_lo[31:0]};
        end
        return m;
    endfunction

endpackage

FILE: src/prml_rule_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prml_rule_mem
// Rule storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prml_rule_mem
    import prml_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  rule_t            wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output rule_t            rd_data
);

    rule_t mem [MAX_RULES];
    rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/prml_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prml_match
// Compares one stored rule against the lookup key and forms its sort key.
// ----------------------------------------------------------------------------
module prml_match
    import prml_pkg::*;
(
    input  rule_t            rule,
    input  logic [IDX_W-1:0] idx,
    input  rule_t            key,
    input  logic             thr_valid,
    input  logic [ORD_W-1:0] thr,
    output match_t           result
);

    logic dst_ok;
    logic src_ok;
    logic tos_ok;
    logic [ORD_W-1:0] ord;

    always_comb
    begin
        dst_ok = ((rule.dst_hi == '0) && (rule.dst_lo == '0)) ||
                 ((rule.dst_hi == key.dst_hi) && (rule.dst_lo == key.dst_lo));
        src_ok = ((rule.src_hi == '0) && (rule.src_lo == '0)) ||
                 ((rule.src_hi == key.src_hi) && (rule.src_lo == key.src_lo));
        tos_ok = (rule.tos == 8'd0) || (rule.tos == key.tos);
        ord    = {rule.priority_req, idx};
        // skip rules already emitted in an earlier pass
        result.hit = (rule.family == key.family) && !rule.names_interface &&
                     dst_ok && src_ok && tos_ok && (!thr_valid || (ord > thr));
        result.ord = ord;
    end

endmodule

FILE: src/policy_rule_match_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// policy_rule_match_lookup_unit
// Policy routing rule table with clear, append and priority-ordered lookup.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                  tuser      tlast
//  s_*      in   family, dst_hi, dst_lo, src_hi,        cmd        -
//                src_lo, tos, priority_req,
//                route_table, names_interface
//  m_*      out  table_id, found                        status     last
//
// Clear and append write their result straight into the output register.
// A lookup makes one pass over the rule memory for each result it emits,
// reading one rule a cycle and keeping the two smallest unemitted
// (priority, index) keys.
// Reset empties the table; no clearing pass is needed.
// The input is held off while a lookup runs or a result waits and cannot move.
module policy_rule_match_lookup_unit
    import prml_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // family, dst_hi, dst_lo, src_hi, src_lo, tos,
                                        // priority_req, route_table, names_interface
    input  logic [1:0]       s_tuser,   // cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // table_id, found
    output logic             m_tuser,   // status
    output logic             m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    rule_t            key_reg, key_next;
    logic             thr_valid_reg, thr_valid_next;
    logic [ORD_W-1:0] thr_reg, thr_next;
    logic             best_valid_reg, best_valid_next;
    logic [ORD_W-1:0] best_reg, best_next;
    logic [31:0]      best_tid_reg, best_tid_next;
    logic             second_valid_reg, second_valid_next;
    logic [ORD_W-1:0] second_reg, second_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_tid_reg, out_tid_next;
    logic             out_found_reg, out_found_next;
    logic             out_last_reg, out_last_next;
    logic             out_status_reg, out_status_next;

    rule_t  in_raw;
    rule_t  in_rule;
    rule_t  rd_rule;
    match_t hit;
    logic   out_free;
    logic   accept;
    logic   wr_en;
    logic   rd_en;

    // unpack tdata, first field in the lowest bits
    always_comb
    begin
        in_raw.family          = s_tdata[0];
        in_raw.dst_hi          = s_tdata[64:1];
        in_raw.dst_lo          = s_tdata[128:65];
        in_raw.src_hi          = s_tdata[192:129];
        in_raw.src_lo          = s_tdata[256:193];
        in_raw.tos             = s_tdata[264:257];
        in_raw.priority_req    = s_tdata[296:265];
        in_raw.route_table     = s_tdata[328:297];
        in_raw.names_interface = s_tdata[329];
    end

    assign in_rule = mask_rule(in_raw);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept = s_tvalid && s_tready;
    assign wr_en = accept && (s_tuser == CMD_APPEND) && (count_reg < CNT_W'(MAX_RULES));
    assign rd_en = (state_reg == S_SCAN) && (issue_reg < count_reg);

    prml_rule_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (in_rule),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_rule)
    );

    prml_match u_match (
        .rule      (rd_rule),
        .idx       (rd_idx_reg),
        .key       (key_reg),
        .thr_valid (thr_valid_reg),
        .thr       (thr_reg),
        .result    (hit)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        issue_next        = issue_reg;
        pend_next         = 1'b0;
        rd_idx_next       = issue_reg[IDX_W-1:0];
        key_next          = key_reg;
        thr_valid_next    = thr_valid_reg;
        thr_next          = thr_reg;
        best_valid_next   = best_valid_reg;
        best_next         = best_reg;
        best_tid_next     = best_tid_reg;
        second_valid_next = second_valid_reg;
        second_next       = second_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_tid_next      = out_tid_reg;
        out_found_next    = out_found_reg;
        out_last_next     = out_last_reg;
        out_status_next   = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    out_tid_next    = '0;
                    out_found_next  = 1'b0;
                    out_last_next   = 1'b1;
                    out_status_next = 1'b0;
                    case (s_tuser)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (wr_en)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                out_status_next = 1'b1;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            // hold the result until the scan settles it
                            out_valid_next    = 1'b0;
                            key_next          = in_rule;
                            thr_valid_next    = 1'b0;
                            best_valid_next   = 1'b0;
                            second_valid_next = 1'b0;
                            issue_next        = '0;
                            state_next        = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                    pend_next  = 1'b1;
                end
                if (pend_reg && hit.hit)
                begin
                    if (!best_valid_reg || (hit.ord < best_reg))
                    begin
                        second_valid_next = best_valid_reg;
                        second_next       = best_reg;
                        best_valid_next   = 1'b1;
                        best_next         = hit.ord;
                        best_tid_next     = rd_rule.route_table;
                    end
                    else if (!second_valid_reg || (hit.ord < second_reg))
                    begin
                        second_valid_next = 1'b1;
                        second_next       = hit.ord;
                    end
                end
                if (!rd_en && !pend_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_tid_next    = best_valid_reg ? best_tid_reg : 32'd0;
                    out_found_next  = best_valid_reg;
                    out_last_next   = !second_valid_reg;
                    out_status_next = 1'b0;
                    if (second_valid_reg)
                    begin
                        // next pass starts above the key just emitted
                        thr_valid_next    = 1'b1;
                        thr_next          = best_reg;
                        best_valid_next   = 1'b0;
                        second_valid_next = 1'b0;
                        issue_next        = '0;
                        state_next        = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            issue_reg        <= '0;
            pend_reg         <= 1'b0;
            thr_valid_reg    <= 1'b0;
            best_valid_reg   <= 1'b0;
            second_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            issue_reg        <= issue_next;
            pend_reg         <= pend_next;
            thr_valid_reg    <= thr_valid_next;
            best_valid_reg   <= best_valid_next;
            second_valid_reg <= second_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        key_reg        <= key_next;
        thr_reg        <= thr_next;
        best_reg       <= best_next;
        best_tid_reg   <= best_tid_next;
        second_reg     <= second_next;
        out_tid_reg    <= out_tid_next;
        out_found_reg  <= out_found_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_found_reg, out_tid_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: src/prml_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prml_checker
// Port-level checks of the policy rule lookup unit.
// ----------------------------------------------------------------------------
module prml_checker
    import prml_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser,
    input logic             m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item dropped or changed while stalled");

    a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> m_tlast)
        else $error("result without a match is not the final one");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && !m_tdata[32] && (m_tdata[31:0] == 32'd0))
        else $error("dropped-rule status on a match result");

    a_no_take_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("new item taken while a lookup still emits");

endmodule

bind policy_rule_match_lookup_unit prml_checker u_prml_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the policy rule lookup unit: a table of directed items followed by
// random clear/append/lookup sequences, each result checked against the row's
// result or an in-bench rule table model; random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    import prml_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N_RANDOM = 240;

    typedef struct packed {
        logic [31:0] route_id;
        logic        found;
        logic        last;
        logic        status;
    } res_t;

    typedef struct {
        logic [1:0] cmd;
        rule_t      r;
        bit         typed;
        res_t       res;
    } row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [1:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    rule_t      rules [MAX_RULES];
    int         n_rules = 0;
    res_t       pending [$];
    row_t       rows [$];
    int         n_errors = 0;
    int         n_sent = 0;
    int         n_results = 0;
    int         n_lookups = 0;
    int         n_full = 0;
    bit         no_gaps = 1'b0;
    logic [63:0] addr_pool [4];

    always #1 clk = ~clk;

    policy_rule_match_lookup_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    function automatic res_t mk_res(logic [31:0] tid, logic fnd, logic lst, logic st);
        res_t x;
        x.route_id = tid;
        x.found    = fnd;
        x.last     = lst;
        x.status   = st;
        return x;
    endfunction

    function automatic bit addr_hit(logic [63:0] rhi, logic [63:0] rlo,
                                    logic [63:0] khi, logic [63:0] klo);
        return (rhi == 64'd0 && rlo == 64'd0) || (rhi == khi && rlo == klo);
    endfunction

    // update the rule table and queue the results one item causes
    task automatic predict_results(input logic [1:0] cmd, input rule_t raw, output res_t q [$]);
        rule_t k;
        int    sel [$];
        int    cur;
        int    j;
        k = raw;
        q = {};
        if (k.family == FAM_IPV4)
        begin
            k.dst_hi = '0;
            k.src_hi = '0;
            k.dst_lo[63:32] = '0;
            k.src_lo[63:32] = '0;
        end
        case (cmd)
            CMD_CLEAR:
            begin
                n_rules = 0;
                q.insert(q.size(), mk_res(32'd0, 1'b0, 1'b1, 1'b0));
            end
            CMD_APPEND:
            begin
                if (n_rules >= MAX_RULES)
                begin
                    n_full++;
                    q.insert(q.size(), mk_res(32'd0, 1'b0, 1'b1, 1'b1));
                end
                else
                begin
                    rules[n_rules] = k;
                    n_rules++;
                    q.insert(q.size(), mk_res(32'd0, 1'b0, 1'b1, 1'b0));
                end
            end
            CMD_LOOKUP:
            begin
                n_lookups++;
                for (int i = 0; i < n_rules; i++)
                    if (rules[i].family == k.family && !rules[i].names_interface &&
                        addr_hit(rules[i].dst_hi, rules[i].dst_lo, k.dst_hi, k.dst_lo) &&
                        addr_hit(rules[i].src_hi, rules[i].src_lo, k.src_hi, k.src_lo) &&
                        (rules[i].tos == 8'd0 || rules[i].tos == k.tos))
                        sel.insert(sel.size(), i);
                // stable sort on priority
                for (int i = 1; i < sel.size(); i++)
                begin
                    cur = sel[i];
                    j = i;
                    while (j > 0 && rules[sel[j-1]].priority_req > rules[cur].priority_req)
                    begin
                        sel[j] = sel[j-1];
                        j--;
                    end
                    sel[j] = cur;
                end
                if (sel.size() == 0)
                    q.insert(q.size(), mk_res(32'd0, 1'b0, 1'b1, 1'b0));
                foreach (sel[i])
                    q.insert(q.size(), mk_res(rules[sel[i]].route_table, 1'b1,
                                              i == sel.size() - 1, 1'b0));
            end
            default: q.insert(q.size(), mk_res(32'd0, 1'b0, 1'b1, 1'b0));
        endcase
    endtask

    // drive one item, hold it until taken, then model it
    task automatic send_item(input logic [1:0] cmd, input rule_t r,
                             input bit typed, input res_t tres);
        res_t q [$];
        int   gap;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {6'd0, r.names_interface, r.route_table, r.priority_req, r.tos,
                    r.src_lo, r.src_hi, r.dst_lo, r.dst_hi, r.family};
        do @(posedge clk); while (!s_tready);
        predict_results(cmd, r, q);
        if (typed)
            pending.insert(pending.size(), tres);
        else
            foreach (q[i]) pending.insert(pending.size(), q[i]);
        n_sent++;
        if (n_sent % 40 == 0)
            no_gaps = ($urandom_range(0, 2) == 0);
        gap = no_gaps ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(8, 30)
                                                         : $urandom_range(0, 2));
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic rule_t rand_rule();
        rule_t r;
        int    p;
        r.family = 1'($urandom_range(0, 1));
        p = $urandom_range(0, 3);
        r.dst_lo = (p == 0) ? 64'd0 : (p == 3) ? rand64() : addr_pool[p];
        r.dst_hi = (p == 0) ? 64'd0 : (p == 3) ? rand64() : addr_pool[p] ^ 64'h5a5a;
        if (r.family == FAM_IPV4 && $urandom_range(0, 1))
            r.dst_hi = rand64();
        p = $urandom_range(0, 3);
        r.src_lo = (p == 0) ? 64'd0 : (p == 3) ? rand64() : addr_pool[p];
        r.src_hi = (p == 0) ? 64'd0 : (p == 3) ? rand64() : addr_pool[p] ^ 64'ha5a5;
        if (r.family == FAM_IPV4 && $urandom_range(0, 1))
            r.src_hi = rand64();
        p = $urandom_range(0, 3);
        r.tos = (p == 0) ? 8'd0 : (p == 1) ? 8'd5 : (p == 2) ? 8'hff : 8'($urandom);
        r.priority_req = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom;
        r.route_table = $urandom;
        r.names_interface = ($urandom_range(0, 5) == 0);
        return r;
    endfunction

    task automatic add_row(logic [1:0] cmd, rule_t r, bit typed, res_t res);
        row_t w;
        w.cmd = cmd;
        w.r = r;
        w.typed = typed;
        w.res = res;
        rows.insert(rows.size(), w);
    endtask

    // receiver with random stalls and one long hold-off
    initial
    begin : receiver
        int  stall_left;
        bit  held;
        stall_left = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && n_sent >= 120)
            begin
                held = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (!no_gaps && $urandom_range(0, 5) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: tid=%h found=%b last=%b status=%b",
                             m_tdata[31:0], m_tdata[32], m_tlast, m_tuser);
            end
            else
            begin
                if (m_tdata[31:0] !== pending[0].route_id || m_tdata[32] !== pending[0].found ||
                    m_tlast !== pending[0].last || m_tuser !== pending[0].status ||
                    m_tdata[OUT_W-1:33] !== '0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp tid=%h found=%b last=%b status=%b, got tid=%h found=%b last=%b status=%b",
                                 pending[0].route_id, pending[0].found, pending[0].last,
                                 pending[0].status, m_tdata[31:0], m_tdata[32], m_tlast, m_tuser);
                end
                void'(pending.pop_front());
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        rule_t        r;
        rule_t        z;
        res_t         none;
        int           n_app;
        bit           did_full;
        logic [351:0] noise;
        did_full = 1'b0;
        foreach (addr_pool[i]) addr_pool[i] = rand64();
        z = '0;
        none = mk_res(32'd0, 1'b0, 1'b1, 1'b0);
        repeat (10) @(posedge clk);
        rst_n = 1'b1;

        add_row(CMD_LOOKUP, z, 1'b1, none);              // lookup on empty table
        add_row(CMD_UNUSED, '1, 1'b1, none);
        add_row(CMD_CLEAR, '1, 1'b1, none);
        r = z; r.priority_req = 5; r.route_table = 10;
        add_row(CMD_APPEND, r, 1'b1, none);              // IPv4 catch-all
        r = '1; r.family = FAM_IPV4; r.dst_lo = 64'hdead_beef_c0a8_0001;
        r.src_lo = 64'hffff_ffff_0000_0000; r.tos = 8'd0; r.priority_req = 5;
        r.route_table = 11; r.names_interface = 1'b0;
        add_row(CMD_APPEND, r, 1'b1, none);              // upper bits to be masked
        r = '1; r.priority_req = 0; r.names_interface = 1'b0;
        add_row(CMD_APPEND, r, 1'b1, none);              // IPv6 all ones
        r = z; r.family = 1'b1; r.names_interface = 1'b1; r.route_table = 99;
        add_row(CMD_APPEND, r, 1'b1, none);              // names interface: never hit
        r = z; r.family = 1'b1; r.tos = 8'hff; r.priority_req = '1; r.route_table = 0;
        add_row(CMD_APPEND, r, 1'b1, none);
        r = z; r.dst_lo = 64'h1234_5678_c0a8_0001; r.dst_hi = '1; r.src_hi = '1;
        add_row(CMD_LOOKUP, r, 1'b0, none);
        r.dst_lo = 64'h0000_0000_c0a8_0002;
        add_row(CMD_LOOKUP, r, 1'b0, none);
        r = '1;
        add_row(CMD_LOOKUP, r, 1'b0, none);
        r = z; r.family = 1'b1; r.tos = 8'hff;
        add_row(CMD_LOOKUP, r, 1'b0, none);
        r.tos = 8'd7;
        add_row(CMD_LOOKUP, r, 1'b0, none);
        add_row(CMD_CLEAR, z, 1'b1, none);
        add_row(CMD_LOOKUP, '1, 1'b1, none);
        foreach (rows[i]) send_item(rows[i].cmd, rows[i].r, rows[i].typed, rows[i].res);

        while (n_sent < rows.size() + N_RANDOM)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                // noise: any command, any bits
                noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom};
                r = noise[$bits(rule_t)-1:0];
                send_item(2'($urandom_range(0, 3)), r, 1'b0, none);
            end
            else
            begin
                send_item(CMD_CLEAR, rand_rule(), 1'b0, none);
                n_app = $urandom_range(0, 8);
                if (!did_full && n_sent > 150)
                begin
                    did_full = 1'b1;
                    n_app = MAX_RULES + 2;
                end
                repeat (n_app) send_item(CMD_APPEND, rand_rule(), 1'b0, none);
                if (n_app > MAX_RULES)
                    send_item(CMD_LOOKUP, z, 1'b0, none);   // catch-all rules hit here
                repeat ($urandom_range(1, 4)) send_item(CMD_LOOKUP, rand_rule(), 1'b0, none);
            end
        end
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d items (%0d lookups, %0d appends on a full table), %0d results",
                 n_sent, n_lookups, n_full, n_results);
        if (n_errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
src/prml_pkg.sv
src/prml_rule_mem.sv
src/prml_match.sv
src/policy_rule_match_lookup_unit.sv
src/prml_checker.sv
bench/tb.sv
